// ===== hdl/jet_color_ramp_assert.svh =====
// Assertion macros for the jet color ramp checker.
// Needs a clk and an rst signal in the scope where a macro is used.
`ifndef JET_COLOR_RAMP_ASSERT_SVH
`define JET_COLOR_RAMP_ASSERT_SVH

// Same-cycle implication, held off while reset is high.
`define JCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication over a fixed delay, held off while reset is high.
`define JCR_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
    else $error(msg);

`endif

// ===== hdl/jcr_pkg.sv =====
// Shared types and constants for the jet color ramp.
// No dependencies.
`timescale 1ns / 1ps

package jcr_pkg;

  // register map: one 32-bit register every 4 bytes
  localparam int ADDR_BITS = 3;
  localparam logic REG_RANGE_LOW  = 1'b0;
  localparam logic REG_RANGE_HIGH = 1'b1;

  // t carries two segment bits above the channel ramp; the quotient has one more
  // bit so that the top of the range (t = 4.0 in ramp units) can be seen and saturated
  localparam int SEG_BITS   = 2;
  localparam int QUOT_EXTRA = SEG_BITS + 1;
  // clamp stage, offset stage and output stage around the divider steps
  localparam int PIPE_EXTRA = 3;

  typedef enum logic [SEG_BITS-1:0] {
    SEG_BLUE_CYAN    = 2'd0,
    SEG_CYAN_GREEN   = 2'd1,
    SEG_GREEN_YELLOW = 2'd2,
    SEG_YELLOW_RED   = 2'd3
  } seg_t;

  // control that travels alongside each word in the pipeline
  typedef struct packed {
    logic valid;
    logic err;
  } jcr_ctl_t;

endpackage

// ===== hdl/jcr_div_step.sv =====
// One registered radix-2 restoring division step of the jet color ramp divider.
// Depends on jcr_pkg for the control struct.
`timescale 1ns / 1ps

module jcr_div_step #(
  parameter int  DATA_BITS  = 16,
  parameter int  QUOT_BITS  = 11,
  parameter bit  FIRST_STEP = 1'b0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  jcr_pkg::jcr_ctl_t      ctl_in,
  input  logic [DATA_BITS-1:0]   rem_in,
  input  logic [DATA_BITS-1:0]   dv_in,
  input  logic [QUOT_BITS-1:0]   q_in,
  output jcr_pkg::jcr_ctl_t      ctl_out,
  output logic [DATA_BITS-1:0]   rem_out,
  output logic [DATA_BITS-1:0]   dv_out,
  output logic [QUOT_BITS-1:0]   q_out
);
  import jcr_pkg::*;

  logic [DATA_BITS:0] cand;
  logic [DATA_BITS:0] diff;
  logic               ge;

  // first step compares the offset itself, later steps the doubled remainder
  always_comb begin
    if (FIRST_STEP) begin
      cand = {1'b0, rem_in};
    end else begin
      cand = {rem_in, 1'b0};
    end
    diff = cand - {1'b0, dv_in};
    ge   = (cand >= {1'b0, dv_in});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  // remainder stays below the divisor, so the top bit drops
  always_ff @(posedge clk) begin
    rem_out <= ge ? diff[DATA_BITS-1:0] : cand[DATA_BITS-1:0];
    dv_out  <= dv_in;
    q_out   <= {q_in[QUOT_BITS-2:0], ge};
  end

endmodule

// ===== hdl/jet_color_ramp.sv =====
// Top level of the jet color ramp: config registers, clamp, divider pipeline, color map.
// Depends on jcr_pkg and jcr_div_step.
`timescale 1ns / 1ps

// Maps one signed sample per clock to a jet-style RGB color. A sample is taken at
// every clock edge where start is high and busy is low; busy is high only during
// reset, so a full-rate stream is accepted. Each result appears on red, green, blue
// and range_error for exactly one cycle with done high, in input order. A sample
// passes a clamp stage, an offset stage, the divider (one registered restoring
// step per quotient bit, COLOR_BITS + 3 of them) and an output stage.
// The receiver must take every word as it comes. range_low and range_high are
// written over the APB port at byte addresses 0 and 4; change them only while no
// sample is in flight. When range_high <= range_low, range_error is set and the
// color is pure blue.
module jet_color_ramp #(
  parameter int SAMPLE_BITS = 16,
  parameter int COLOR_BITS  = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // sample channel
  input  logic                          start,
  output logic                          busy,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  // result channel
  output logic                          done,
  output logic [COLOR_BITS-1:0]         red,
  output logic [COLOR_BITS-1:0]         green,
  output logic [COLOR_BITS-1:0]         blue,
  output logic                          range_error,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jcr_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import jcr_pkg::*;

  localparam int QUOT_BITS = COLOR_BITS + QUOT_EXTRA;
  localparam int T_BITS    = COLOR_BITS + SEG_BITS;
  localparam logic signed [SAMPLE_BITS-1:0] RESET_HIGH = SAMPLE_BITS'(32'sd32767);

  // ---------------- configuration ----------------
  logic signed [SAMPLE_BITS-1:0] range_low;
  logic signed [SAMPLE_BITS-1:0] range_high;
  logic                          cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= '0;
      range_high <= RESET_HIGH;
    end else if (cfg_write) begin
      if (paddr[2] == REG_RANGE_LOW) begin
        range_low <= pwdata[SAMPLE_BITS-1:0];
      end else begin
        range_high <= pwdata[SAMPLE_BITS-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_RANGE_LOW) begin
      prdata = 32'(unsigned'(range_low));
    end else begin
      prdata = 32'(unsigned'(range_high));
    end
  end

  assign busy = rst;

  // ---------------- stage 1: clamp ----------------
  jcr_ctl_t                      ctl_c;
  logic signed [SAMPLE_BITS-1:0] clamped;
  logic signed [SAMPLE_BITS-1:0] clamp_next;
  logic                          bad_range;

  assign bad_range = !(range_high > range_low);

  always_comb begin
    if (sample < range_low) begin
      clamp_next = range_low;
    end else if (sample > range_high) begin
      clamp_next = range_high;
    end else begin
      clamp_next = sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_c <= '0;
    end else begin
      ctl_c.valid <= start && !busy;
      ctl_c.err   <= bad_range;
    end
  end

  always_ff @(posedge clk) begin
    clamped <= clamp_next;
  end

  // ---------------- stage 2: offset and span ----------------
  // for a valid range both differences are non-negative and fit SAMPLE_BITS unsigned
  logic signed [SAMPLE_BITS:0] offs_wide;
  logic signed [SAMPLE_BITS:0] span_wide;

  assign offs_wide = (SAMPLE_BITS+1)'(clamped) - (SAMPLE_BITS+1)'(range_low);
  assign span_wide = (SAMPLE_BITS+1)'(range_high) - (SAMPLE_BITS+1)'(range_low);

  jcr_ctl_t               ctl_s [0:QUOT_BITS];
  logic [SAMPLE_BITS-1:0] rem_s [0:QUOT_BITS];
  logic [SAMPLE_BITS-1:0] dv_s  [0:QUOT_BITS];
  logic [QUOT_BITS-1:0]   q_s   [0:QUOT_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_s[0] <= '0;
    end else begin
      ctl_s[0] <= ctl_c;
    end
  end

  // a bad range divides zero by one, which lands on t = 0
  always_ff @(posedge clk) begin
    if (ctl_c.err) begin
      rem_s[0] <= '0;
      dv_s[0]  <= SAMPLE_BITS'(1);
    end else begin
      rem_s[0] <= offs_wide[SAMPLE_BITS-1:0];
      dv_s[0]  <= span_wide[SAMPLE_BITS-1:0];
    end
    q_s[0] <= '0;
  end

  // ---------------- divider: one quotient bit per stage ----------------
  for (genvar i = 0; i < QUOT_BITS; i++) begin : g_div
    jcr_div_step #(
      .DATA_BITS (SAMPLE_BITS),
      .QUOT_BITS (QUOT_BITS),
      .FIRST_STEP(i == 0)
    ) u_step (
      .clk    (clk),
      .rst    (rst),
      .ctl_in (ctl_s[i]),
      .rem_in (rem_s[i]),
      .dv_in  (dv_s[i]),
      .q_in   (q_s[i]),
      .ctl_out(ctl_s[i+1]),
      .rem_out(rem_s[i+1]),
      .dv_out (dv_s[i+1]),
      .q_out  (q_s[i+1])
    );
  end

  // ---------------- output stage: saturate and map ----------------
  logic [QUOT_BITS-1:0]  quot;
  logic [T_BITS-1:0]     t_sat;
  logic [COLOR_BITS-1:0] ramp;
  seg_t                  seg;
  logic [COLOR_BITS-1:0] red_next;
  logic [COLOR_BITS-1:0] green_next;
  logic [COLOR_BITS-1:0] blue_next;

  assign quot  = q_s[QUOT_BITS];
  // only the very top of the range sets the extra quotient bit
  assign t_sat = quot[QUOT_BITS-1] ? '1 : quot[T_BITS-1:0];
  assign ramp  = t_sat[COLOR_BITS-1:0];
  assign seg   = seg_t'(t_sat[T_BITS-1:COLOR_BITS]);

  always_comb begin
    case (seg)
      SEG_BLUE_CYAN: begin
        red_next   = '0;
        green_next = ramp;
        blue_next  = '1;
      end
      SEG_CYAN_GREEN: begin
        red_next   = '0;
        green_next = '1;
        blue_next  = ~ramp;
      end
      SEG_GREEN_YELLOW: begin
        red_next   = ramp;
        green_next = '1;
        blue_next  = '0;
      end
      default: begin
        red_next   = '1;
        green_next = ~ramp;
        blue_next  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_s[QUOT_BITS].valid;
    end
  end

  always_ff @(posedge clk) begin
    red         <= red_next;
    green       <= green_next;
    blue        <= blue_next;
    range_error <= ctl_s[QUOT_BITS].err;
  end

endmodule

// ===== hdl/jcr_checker.sv =====
// Port-level checks for jet_color_ramp, attached by bind at the end of this file.
// Depends on jcr_pkg and jet_color_ramp_assert.svh.
`timescale 1ns / 1ps
`include "jet_color_ramp_assert.svh"

module jcr_checker #(
  parameter int SAMPLE_BITS = 16,
  parameter int COLOR_BITS  = 8
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic signed [SAMPLE_BITS-1:0] sample,
  input logic                          done,
  input logic [COLOR_BITS-1:0]         red,
  input logic [COLOR_BITS-1:0]         green,
  input logic [COLOR_BITS-1:0]         blue,
  input logic                          range_error
);
  import jcr_pkg::*;

  localparam int LATENCY = COLOR_BITS + QUOT_EXTRA + PIPE_EXTRA;
  localparam logic [COLOR_BITS-1:0] FULL = '1;

  logic take;
  assign take = start && !busy;

  `JCR_ASSERT_NOW(a_sample_known, take, !$isunknown(sample), "accepted sample has unknown bits")
  `JCR_ASSERT_DELAY(a_word_out, take, LATENCY, done, "accepted sample produced no word")
  `JCR_ASSERT_NOW(a_no_extra, done, $past(take, LATENCY),
                  "word without a matching sample")
  `JCR_ASSERT_NOW(a_jet_shape, done,
                  (red == FULL || green == FULL || blue == FULL) && (red == '0 || blue == '0),
                  "color off the jet ramp")
  `JCR_ASSERT_NOW(a_err_blue, done && range_error,
                  red == '0 && green == '0 && blue == FULL,
                  "bad range must give pure blue")

endmodule

bind jet_color_ramp jcr_checker #(
  .SAMPLE_BITS(SAMPLE_BITS),
  .COLOR_BITS (COLOR_BITS)
) u_jcr_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .sample     (sample),
  .done       (done),
  .red        (red),
  .green      (green),
  .blue       (blue),
  .range_error(range_error)
);

// ===== sim/jet_color_ramp_checker.sv =====
`timescale 1ns / 1ps
// Checker for the jet color ramp: watches the APB port and both word channels,
// predicts each color word and compares it field by field. Depends on jcr_pkg.

module jet_color_ramp_checker #(
  parameter int SAMPLE_BITS = 16,
  parameter int COLOR_BITS  = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          done,
  input  logic [COLOR_BITS-1:0]         red,
  input  logic [COLOR_BITS-1:0]         green,
  input  logic [COLOR_BITS-1:0]         blue,
  input  logic                          range_error,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jcr_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  input  logic [31:0]                   prdata,
  input  logic                          pready,
  output int                            mismatches,
  output int                            pending,
  output int                            checked,
  output int                            flagged
);
  import jcr_pkg::*;

  localparam int T_BITS = COLOR_BITS + SEG_BITS;
  localparam longint T_MAX = (longint'(1) << T_BITS) - 1;
  localparam logic [COLOR_BITS-1:0] FULL = '1;
  localparam logic signed [SAMPLE_BITS-1:0] RESET_HIGH = SAMPLE_BITS'(32'sd32767);
  localparam logic [ADDR_BITS-1:0] LOW_ADDR  = {REG_RANGE_LOW, 2'b00};
  localparam logic [ADDR_BITS-1:0] HIGH_ADDR = {REG_RANGE_HIGH, 2'b00};

  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
    logic                  err;
  } pixel_t;

  logic signed [SAMPLE_BITS-1:0] low_bound;
  logic signed [SAMPLE_BITS-1:0] high_bound;
  pixel_t                        pixel_queue[$];

  function automatic pixel_t jet_pixel(logic signed [SAMPLE_BITS-1:0] v,
                                       logic signed [SAMPLE_BITS-1:0] lo,
                                       logic signed [SAMPLE_BITS-1:0] hi);
    pixel_t                px;
    longint                t;
    logic [COLOR_BITS-1:0] f;
    seg_t                  seg;
    t = 0;
    px.err = 1'b0;
    if (hi <= lo) begin
      px.err = 1'b1;
    end else begin
      if (v < lo) v = lo;
      else if (v > hi) v = hi;
      t = ((longint'(v) - longint'(lo)) <<< T_BITS) / (longint'(hi) - longint'(lo));
      // top of the range lands one past the last code
      if (t > T_MAX) t = T_MAX;
    end
    f = t[COLOR_BITS-1:0];
    seg = seg_t'(t[COLOR_BITS +: SEG_BITS]);
    case (seg)
      SEG_BLUE_CYAN: begin
        px.red = '0; px.green = f; px.blue = FULL;
      end
      SEG_CYAN_GREEN: begin
        px.red = '0; px.green = FULL; px.blue = FULL - f;
      end
      SEG_GREEN_YELLOW: begin
        px.red = f; px.green = FULL; px.blue = '0;
      end
      default: begin
        px.red = FULL; px.green = FULL - f; px.blue = '0;
      end
    endcase
    return px;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("%0t checker: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      low_bound = '0;
      high_bound = RESET_HIGH;
      pixel_queue.delete();
      mismatches = 0;
      checked = 0;
      flagged = 0;
    end else begin
      if (done) begin
        if (pixel_queue.size() == 0) begin
          flag_mismatch("color word with none expected");
        end else begin
          want = pixel_queue.pop_front();
          checked++;
          if (want.err) flagged++;
          if (red !== want.red)
            flag_mismatch($sformatf("red %0d, expected %0d", red, want.red));
          if (green !== want.green)
            flag_mismatch($sformatf("green %0d, expected %0d", green, want.green));
          if (blue !== want.blue)
            flag_mismatch($sformatf("blue %0d, expected %0d", blue, want.blue));
          if (range_error !== want.err)
            flag_mismatch($sformatf("range_error %b, expected %b", range_error, want.err));
        end
      end
      if (start && !busy)
        pixel_queue.push_back(jet_pixel(sample, low_bound, high_bound));
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == LOW_ADDR) low_bound = pwdata[SAMPLE_BITS-1:0];
          else if (paddr == HIGH_ADDR) high_bound = pwdata[SAMPLE_BITS-1:0];
        end else if (paddr == LOW_ADDR && prdata[SAMPLE_BITS-1:0] !== low_bound) begin
          flag_mismatch($sformatf("range_low reads %h, expected %h",
                                  prdata[SAMPLE_BITS-1:0], low_bound));
        end else if (paddr == HIGH_ADDR && prdata[SAMPLE_BITS-1:0] !== high_bound) begin
          flag_mismatch($sformatf("range_high reads %h, expected %h",
                                  prdata[SAMPLE_BITS-1:0], high_bound));
        end
      end
    end
    pending = pixel_queue.size();
  end

endmodule

// ===== sim/jet_color_ramp_tb.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the jet color ramp: directed and random samples over
// many range settings. Depends on jcr_pkg, jet_color_ramp and jet_color_ramp_checker.

module jet_color_ramp_tb;
  import jcr_pkg::*;

  localparam int SAMPLE_BITS     = 16;
  localparam int COLOR_BITS      = 8;
  localparam int RANDOM_PHASES   = 8;
  localparam int WORDS_PER_PHASE = 138;
  localparam int SETTLE_CYCLES   = COLOR_BITS + 6;
  localparam int QUIET_FIRST     = 400;
  localparam int QUIET_LAST      = 650;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic signed [SAMPLE_BITS-1:0] sample = '0;
  logic                          done;
  logic [COLOR_BITS-1:0]         red;
  logic [COLOR_BITS-1:0]         green;
  logic [COLOR_BITS-1:0]         blue;
  logic                          range_error;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [ADDR_BITS-1:0]          paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  int mismatches;
  int pending;
  int checked;
  int flagged;
  int sent = 0;
  int settings = 1;

  logic signed [SAMPLE_BITS-1:0] cur_low = '0;
  logic signed [SAMPLE_BITS-1:0] cur_high = 16'sd32767;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  jet_color_ramp #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COLOR_BITS (COLOR_BITS)
  ) u_dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .sample(sample),
    .done(done), .red(red), .green(green), .blue(blue), .range_error(range_error),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  jet_color_ramp_checker #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COLOR_BITS (COLOR_BITS)
  ) u_checker (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .sample(sample),
    .done(done), .red(red), .green(green), .blue(blue), .range_error(range_error),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .mismatches(mismatches), .pending(pending), .checked(checked), .flagged(flagged)
  );

  // one APB transfer; leaves psel high so transfers can run back to back
  task automatic apb_transfer(input logic idx, input logic wr,
                              input logic signed [SAMPLE_BITS-1:0] value);
    logic [31:0] junk;
    junk = $urandom();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= {junk[31:SAMPLE_BITS], value};
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
  endtask

  task automatic drain_colors();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic set_range(input logic signed [SAMPLE_BITS-1:0] lo,
                           input logic signed [SAMPLE_BITS-1:0] hi);
    drain_colors();
    apb_transfer(REG_RANGE_LOW, 1'b1, lo);
    apb_transfer(REG_RANGE_HIGH, 1'b1, hi);
    apb_transfer(REG_RANGE_LOW, 1'b0, '0);
    apb_transfer(REG_RANGE_HIGH, 1'b0, '0);
    psel <= 1'b0;
    penable <= 1'b0;
    cur_low = lo;
    cur_high = hi;
    settings++;
  endtask

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value,
                             input logic allow_gap);
    if (allow_gap) begin
      // idle a random run of cycles, one more with each hit
      while ($urandom_range(99) < 17) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    sample <= value;
    // busy only moves on a rising edge, so its value here holds at the next one
    do @(negedge clk); while (busy);
    @(posedge clk);
    sent++;
  endtask

  task automatic directed(input logic signed [SAMPLE_BITS-1:0] lo,
                          input logic signed [SAMPLE_BITS-1:0] hi,
                          input logic signed [SAMPLE_BITS-1:0] value);
    if (lo !== cur_low || hi !== cur_high) set_range(lo, hi);
    send_sample(value, 1'b1);
  endtask

  initial begin
    logic signed [SAMPLE_BITS-1:0] a;
    logic signed [SAMPLE_BITS-1:0] b;
    logic signed [SAMPLE_BITS-1:0] lo;
    logic signed [SAMPLE_BITS-1:0] hi;
    logic signed [SAMPLE_BITS-1:0] value;
    int                            span;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset range: clamp below, segment edges, top of range saturates to red
    directed(0, 32767, -32768);
    directed(0, 32767, 0);
    directed(0, 32767, 8192);
    directed(0, 32767, 24575);
    directed(0, 32767, 32766);
    directed(0, 32767, 32767);
    // widest range
    directed(-32768, 32767, -32768);
    directed(-32768, 32767, -1);
    directed(-32768, 32767, 0);
    directed(-32768, 32767, 16383);
    directed(-32768, 32767, 32767);
    // empty and inverted ranges flag an error and give blue
    directed(1234, 1234, 1234);
    directed(1234, 1234, -32768);
    directed(32767, -32768, 0);
    // span of 1024: each sample is one step of t
    directed(-512, 512, -256);
    directed(-512, 512, -1);
    directed(-512, 512, 0);
    directed(-512, 512, 255);
    directed(-512, 512, 256);
    directed(-512, 512, 512);
    // narrowest valid range, clamp above
    directed(0, 1, 0);
    directed(0, 1, 32767);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      a = SAMPLE_BITS'($urandom());
      b = SAMPLE_BITS'($urandom());
      if (p == 0) begin
        lo = -32768;
        hi = 32767;
      end else if (p == 1 || $urandom_range(4) == 0) begin
        lo = (a > b) ? a : b;
        hi = (a > b) ? b : a;
      end else if ($urandom_range(2) == 0) begin
        lo = a;
        span = int'(a) + int'($urandom_range(64, 1));
        hi = (span > 32767) ? 16'sd32767 : span[SAMPLE_BITS-1:0];
      end else begin
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
      end
      set_range(lo, hi);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (hi > lo && $urandom_range(9) < 7) begin
          span = int'(lo) + int'($urandom_range(int'(hi) - int'(lo)));
          value = span[SAMPLE_BITS-1:0];
        end else begin
          value = SAMPLE_BITS'($urandom());
        end
        send_sample(value, !(sent >= QUIET_FIRST && sent < QUIET_LAST));
      end
    end

    drain_colors();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("tb: %0d samples driven over %0d range settings", sent, settings);
    $display("tb: %0d colors compared, %0d with the range flagged empty", checked, flagged);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: timeout");
    $display("tb: failure");
    $finish;
  end

endmodule
